@@ design/dssd_pkg.sv @@
// ============================================================================
// dssd_pkg
// Shared types, constants and the segment code table of the decimal
// seven-segment scan driver.
// ============================================================================
package dssd_pkg;

	// Digit positions shown and buffer geometry
	localparam int DIGIT_COUNT = 8;
	localparam int POS_W       = 3;
	localparam int BUF_DEPTH   = 2 ** POS_W;
	localparam int VALUE_W     = 27;
	localparam int BCD_W       = 4 * DIGIT_COUNT;
	localparam int CNT_W       = $clog2(VALUE_W);
	localparam int SEG_W       = 8;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGIT_COUNT - 1);

	// Item kinds
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_SCAN = 1'b1
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PLACE,
		ST_SCAN
	} state_t;

	// Converter status toward the sequencer
	typedef struct packed {
		logic done;
		logic ovf;
	} bcd_status_t;

	// Placement control toward the segment buffer
	typedef struct packed {
		logic start;
		logic ovf;
	} place_ctrl_t;

	// Common-cathode pattern of one decimal digit, bit0 = a .. bit6 = g
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
		logic [SEG_W-1:0] code;
		case (digit)
			4'd0:    code = 8'h3F;
			4'd1:    code = 8'h06;
			4'd2:    code = 8'h5B;
			4'd3:    code = 8'h4F;
			4'd4:    code = 8'h66;
			4'd5:    code = 8'h6D;
			4'd6:    code = 8'h7D;
			4'd7:    code = 8'h07;
			4'd8:    code = 8'h7F;
			4'd9:    code = 8'h6F;
			default: code = 8'h00;
		endcase
		return code;
	endfunction

endpackage

@@ design/dssd_item_if.sv @@
// ============================================================================
// dssd_item_if
// Command channel: a load or scan request with its binary value.
// ============================================================================
interface dssd_item_if;
	logic                         valid;
	logic                         ready;
	logic                         opcode;
	logic [dssd_pkg::VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

@@ design/dssd_result_if.sv @@
// ============================================================================
// dssd_result_if
// Display channel: one digit position and its segment pattern per transaction.
// ============================================================================
interface dssd_result_if;
	logic                       valid;
	logic                       ready;
	logic [dssd_pkg::POS_W-1:0] digit_select;
	logic [dssd_pkg::SEG_W-1:0] segments;
	logic                       last_digit;

	modport source (output valid, output digit_select, output segments, output last_digit,
		input ready);
	modport sink   (input valid, input digit_select, input segments, input last_digit,
		output ready);
endinterface

@@ design/dssd_bcd_unit.sv @@
// ============================================================================
// dssd_bcd_unit
// Iterative binary to BCD converter: one add-3 and shift step per cycle.
// Digits above the buffer width fall off the top and set a sticky flag.
// ============================================================================
module dssd_bcd_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dssd_pkg::VALUE_W-1:0] value,
	output dssd_pkg::bcd_status_t        status,
	output logic [dssd_pkg::BCD_W-1:0]   bcd
);

	logic                         busy_q;
	logic                         done_q;
	logic                         ovf_q;
	logic [dssd_pkg::CNT_W-1:0]   cnt_q;
	logic [dssd_pkg::VALUE_W-1:0] bin_q;
	logic [dssd_pkg::BCD_W-1:0]   bcd_q;
	logic [dssd_pkg::BCD_W-1:0]   adj;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < dssd_pkg::DIGIT_COUNT; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Step counter and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ovf_q  <= 1'b0;
				cnt_q  <= dssd_pkg::CNT_W'(dssd_pkg::VALUE_W - 1);
			end else if (busy_q) begin
				ovf_q <= ovf_q | adj[dssd_pkg::BCD_W-1];
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Shift the binary value into the digit register, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bcd_q <= {adj[dssd_pkg::BCD_W-2:0], bin_q[dssd_pkg::VALUE_W-1]};
			bin_q <= {bin_q[dssd_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	assign status.done = done_q;
	assign status.ovf  = ovf_q;
	assign bcd         = bcd_q;

endmodule

@@ design/dssd_seg_buffer.sv @@
// ============================================================================
// dssd_seg_buffer
// Segment buffer with a placement sweep that writes one position per cycle,
// leftmost first, blanking leading zeros.
// ============================================================================
module dssd_seg_buffer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dssd_pkg::place_ctrl_t      ctrl,
	input  logic [dssd_pkg::BCD_W-1:0] bcd,
	output logic                       done,
	input  logic [dssd_pkg::POS_W-1:0] rd_addr,
	output logic [dssd_pkg::SEG_W-1:0] rd_data
);

	logic                       busy_q;
	logic                       done_q;
	logic                       seen_q;
	logic [dssd_pkg::POS_W-1:0] pos_q;
	logic [dssd_pkg::BCD_W-1:0] digits_q;
	logic [dssd_pkg::SEG_W-1:0] buf_q [dssd_pkg::BUF_DEPTH];
	logic [3:0]                 top_digit;
	logic                       show;
	logic [dssd_pkg::SEG_W-1:0] wdata;

	// Decide blank or pattern for the current position
	always_comb begin
		top_digit = digits_q[dssd_pkg::BCD_W-1 -: 4];
		show      = seen_q || (top_digit != 4'd0) || (pos_q == dssd_pkg::LAST_POS);
		wdata     = show ? dssd_pkg::seg_code(top_digit) : '0;
	end

	// Sweep positions and write the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			seen_q <= 1'b0;
			pos_q  <= '0;
			for (int i = 0; i < dssd_pkg::BUF_DEPTH; i++) begin
				buf_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				seen_q <= ctrl.ovf;
				pos_q  <= '0;
			end else if (busy_q) begin
				buf_q[pos_q] <= wdata;
				seen_q       <= show;
				if (pos_q == dssd_pkg::LAST_POS) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	// Advance to the next digit, most significant first
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			digits_q <= bcd;
		end else if (busy_q) begin
			digits_q <= {digits_q[dssd_pkg::BCD_W-5:0], 4'd0};
		end
	end

	assign done    = done_q;
	assign rd_data = buf_q[rd_addr];

endmodule

@@ design/decimal_seven_segment_scan_driver_core.sv @@
// ============================================================================
// decimal_seven_segment_scan_driver_core
// Eight-digit decimal seven-segment driver with an iterative BCD converter.
// ============================================================================
// Usage:
//   item   : command channel. opcode OP_LOAD converts value into the display
//            buffer and gives no result; opcode OP_SCAN emits eight results.
//   result : one transaction per digit position, 0 (leftmost) to 7, with its
//            common-cathode segment byte; last_digit marks position 7.
// Timing:
//   A load runs 27 add-3/shift steps on the converter, then buffer placement
//   of the eight positions; item.ready returns once placement is done.
//   A scan presents one position per cycle while result.ready is high;
//   item.ready returns after the last transaction.
//   One item is worked on at a time; item.ready is low while busy.
// Reset:
//   arst_n clears the sequencer and blanks every buffer position.
// Stall:
//   A low result.ready holds the current position and its pattern steady.
//   Values beyond eight digits keep their eight low digits, all shown.
// ============================================================================
module decimal_seven_segment_scan_driver_core (
	input  logic          clk,
	input  logic          arst_n,
	dssd_item_if.sink     item,
	dssd_result_if.source result
);

	dssd_pkg::state_t           state_q;
	dssd_pkg::state_t           state_d;
	logic [dssd_pkg::POS_W-1:0] scan_pos_q;
	logic [dssd_pkg::POS_W-1:0] scan_pos_d;
	logic                       item_acc;
	logic                       res_acc;
	logic                       conv_start;
	logic                       place_done;
	dssd_pkg::bcd_status_t      conv_status;
	dssd_pkg::place_ctrl_t      place_ctrl;
	logic [dssd_pkg::BCD_W-1:0] bcd;
	logic [dssd_pkg::SEG_W-1:0] rd_data;

	dssd_bcd_unit u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (item.value),
		.status (conv_status),
		.bcd    (bcd)
	);

	dssd_seg_buffer u_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (place_ctrl),
		.bcd     (bcd),
		.done    (place_done),
		.rd_addr (scan_pos_q),
		.rd_data (rd_data)
	);

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dssd_pkg::ST_IDLE;
			scan_pos_q <= '0;
		end else begin
			state_q    <= state_d;
			scan_pos_q <= scan_pos_d;
		end
	end

	// Next state and channel outputs
	always_comb begin
		state_d             = state_q;
		scan_pos_d          = scan_pos_q;
		item.ready          = (state_q == dssd_pkg::ST_IDLE);
		item_acc            = item.valid && item.ready;
		result.valid        = (state_q == dssd_pkg::ST_SCAN);
		res_acc             = result.valid && result.ready;
		result.digit_select = scan_pos_q;
		result.segments     = rd_data;
		result.last_digit   = (scan_pos_q == dssd_pkg::LAST_POS);
		conv_start          = 1'b0;
		place_ctrl.start    = 1'b0;
		place_ctrl.ovf      = conv_status.ovf;
		case (state_q)
			dssd_pkg::ST_IDLE: begin
				if (item_acc) begin
					if (item.opcode == dssd_pkg::OP_LOAD) begin
						conv_start = 1'b1;
						state_d    = dssd_pkg::ST_CONV;
					end else begin
						scan_pos_d = '0;
						state_d    = dssd_pkg::ST_SCAN;
					end
				end
			end
			dssd_pkg::ST_CONV: begin
				if (conv_status.done) begin
					place_ctrl.start = 1'b1;
					state_d          = dssd_pkg::ST_PLACE;
				end
			end
			dssd_pkg::ST_PLACE: begin
				if (place_done) begin
					state_d = dssd_pkg::ST_IDLE;
				end
			end
			dssd_pkg::ST_SCAN: begin
				if (res_acc) begin
					if (result.last_digit) begin
						state_d = dssd_pkg::ST_IDLE;
					end else begin
						scan_pos_d = scan_pos_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = dssd_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef ASSERT_OFF
	// Commands and results never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !result.valid)
		else $error("command taken while results pending");

	// A taken load starts conversion on the next cycle
	a_load_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.opcode == dssd_pkg::OP_LOAD) |=> state_q == dssd_pkg::ST_CONV)
		else $error("load did not start conversion");

	// A taken scan starts at the leftmost position
	a_scan_first: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && item.opcode == dssd_pkg::OP_SCAN) |=>
		(result.valid && result.digit_select == '0))
		else $error("scan did not start at position zero");

	// Positions advance by one after each non-final transaction
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && !result.last_digit) |=>
		(result.valid && result.digit_select == $past(result.digit_select) + 1'b1))
		else $error("scan position skipped");

	// Placement finishes only while placing
	a_place_done: assert property (@(posedge clk) disable iff (!arst_n)
		place_done |-> state_q == dssd_pkg::ST_PLACE)
		else $error("placement done outside placement");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal seven-segment scan driver. Load and
// scan transactions go in through the command channel; a scoreboard keeps
// its own image of the eight-digit segment buffer and queues the eight
// digit transactions that every scan must produce. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 200;
	localparam int SETTLE_CYCLES = 64;
	localparam int LIMIT_CYCLES = 300000;
	localparam logic [dssd_pkg::VALUE_W-1:0] VALUE_MAX = {dssd_pkg::VALUE_W{1'b1}};

	// Expected image of the display and its pending digit transactions
	class display_scoreboard;
		typedef struct {
			logic [dssd_pkg::POS_W-1:0] pos;
			logic [dssd_pkg::SEG_W-1:0] seg;
			logic                       last;
		} digit_result_t;

		logic [dssd_pkg::SEG_W-1:0] digit_code [10];
		logic [dssd_pkg::SEG_W-1:0] shown [dssd_pkg::BUF_DEPTH];
		digit_result_t              pending_digits [$];
		int                         errors;

		function new();
			digit_code = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
				8'h7F, 8'h6F};
			foreach (shown[i]) shown[i] = '0;
			errors = 0;
		endfunction

		function int pending();
			return pending_digits.size();
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("MISMATCH at %0t ns: %s", $time, what);
		endtask

		// Update the image on a load, or queue a full scan
		function void note_item(dssd_pkg::op_t op, logic [dssd_pkg::VALUE_W-1:0] value);
			int unsigned   rest;
			int unsigned   p;
			digit_result_t d;
			if (op == dssd_pkg::OP_LOAD) begin
				rest = value;
				p = dssd_pkg::DIGIT_COUNT;
				foreach (shown[i]) shown[i] = '0;
				if (rest == 0)
					shown[dssd_pkg::DIGIT_COUNT-1] = digit_code[0];
				// Fill from the right; digits beyond the display drop out
				while (rest != 0 && p > 0) begin
					p--;
					shown[p] = digit_code[rest % 10];
					rest = rest / 10;
				end
			end else begin
				for (int i = 0; i < dssd_pkg::DIGIT_COUNT; i++) begin
					d.pos  = dssd_pkg::POS_W'(i);
					d.seg  = shown[i];
					d.last = (i == dssd_pkg::DIGIT_COUNT - 1);
					pending_digits.push_back(d);
				end
			end
		endfunction

		// Compare one digit transaction against the oldest expectation
		task check_result(logic [dssd_pkg::POS_W-1:0] pos, logic [dssd_pkg::SEG_W-1:0] seg,
			logic last);
			digit_result_t d;
			if (pending_digits.size() == 0) begin
				report_mismatch($sformatf("unexpected digit pos=%0d seg=%h", pos, seg));
			end else begin
				d = pending_digits.pop_front();
				if (pos !== d.pos)
					report_mismatch($sformatf("digit_select %0d, want %0d", pos, d.pos));
				if (seg !== d.seg)
					report_mismatch($sformatf("segments %h at pos %0d, want %h",
						seg, d.pos, d.seg));
				if (last !== d.last)
					report_mismatch($sformatf("last_digit %b at pos %0d, want %b",
						last, d.pos, d.last));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   burst_left = 0;

	dssd_item_if   item ();
	dssd_result_if result ();

	display_scoreboard board = new();

	decimal_seven_segment_scan_driver_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Hold reset at start-up, then release it for good
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Watch both channels; commands are noted before results of the same edge
	always @(posedge clk) begin
		if (arst_n && item.valid && item.ready)
			board.note_item(dssd_pkg::op_t'(item.opcode), item.value);
		if (arst_n && result.valid && result.ready)
			board.check_result(result.digit_select, result.segments, result.last_digit);
	end

	// Stall the display side: always ready, random drops, or a periodic gap
	initial begin
		int mode;
		int span;
		int period;
		result.ready <= 1'b0;
		forever begin
			mode   = $urandom_range(0, 2);
			span   = $urandom_range(10, 80);
			period = $urandom_range(2, 7);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
					0: begin
						result.ready <= 1'b1;
					end
					1: begin
						result.ready <= ($urandom_range(0, 2) != 0);
					end
					default: begin
						result.ready <= ((i % period) == 0);
					end
				endcase
			end
		end
	end

	// Present one command and hold it until taken
	task send_item(dssd_pkg::op_t op, logic [dssd_pkg::VALUE_W-1:0] value);
		item.valid  <= 1'b1;
		item.opcode <= op;
		item.value  <= value;
		do @(posedge clk); while (!item.ready);
	endtask

	// Drop valid and put junk on the bus while idling
	task idle_sender(int n);
		if (n > 0) begin
			item.valid  <= 1'b0;
			item.opcode <= $urandom_range(0, 1);
			item.value  <= dssd_pkg::VALUE_W'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// Advance the burst pattern after each transaction
	task pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_sender($urandom_range(1, 8));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// Values spread over every digit count, plus the range past eight digits
	function automatic logic [dssd_pkg::VALUE_W-1:0] random_value();
		int          digits;
		int unsigned lo;
		int unsigned hi;
		digits = $urandom_range(0, 10);
		if (digits == 0)
			return '0;
		if (digits == 9)
			return dssd_pkg::VALUE_W'($urandom_range(100000000, VALUE_MAX));
		if (digits == 10)
			return dssd_pkg::VALUE_W'($urandom);
		hi = 1;
		for (int i = 0; i < digits; i++) hi = hi * 10;
		lo = (digits == 1) ? 1 : hi / 10;
		return dssd_pkg::VALUE_W'($urandom_range(lo, hi - 1));
	endfunction

	task load_and_scan(logic [dssd_pkg::VALUE_W-1:0] value);
		send_item(dssd_pkg::OP_LOAD, value);
		pace_sender();
		send_item(dssd_pkg::OP_SCAN, dssd_pkg::VALUE_W'($urandom));
		pace_sender();
	endtask

	initial begin
		int  sent;
		int  pick;
		bit  drained;
		item.valid  <= 1'b0;
		item.opcode <= dssd_pkg::OP_LOAD;
		item.value  <= '0;
		while (!arst_n) @(posedge clk);
		@(posedge clk);

		// Directed: blank display after reset, zero, edges of the value range
		send_item(dssd_pkg::OP_SCAN, '0);
		pace_sender();
		load_and_scan('0);
		load_and_scan(dssd_pkg::VALUE_W'(7));
		load_and_scan(dssd_pkg::VALUE_W'(99999999));
		load_and_scan(VALUE_MAX);
		load_and_scan(dssd_pkg::VALUE_W'(100000000));
		load_and_scan(dssd_pkg::VALUE_W'(10203040));
		load_and_scan(dssd_pkg::VALUE_W'(27'h5555555));
		load_and_scan(dssd_pkg::VALUE_W'(27'h2AAAAAA));
		send_item(dssd_pkg::OP_LOAD, dssd_pkg::VALUE_W'(99999));
		pace_sender();
		send_item(dssd_pkg::OP_LOAD, dssd_pkg::VALUE_W'(10));
		pace_sender();
		send_item(dssd_pkg::OP_SCAN, VALUE_MAX);
		pace_sender();
		send_item(dssd_pkg::OP_SCAN, '0);
		pace_sender();

		// Random: mostly load/scan pairs, the rest lone scans and loads
		sent = 0;
		drained = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				load_and_scan(random_value());
				sent += 2;
			end else if (pick < 85) begin
				send_item(dssd_pkg::OP_SCAN, dssd_pkg::VALUE_W'($urandom));
				pace_sender();
				sent++;
			end else begin
				send_item(dssd_pkg::OP_LOAD, random_value());
				pace_sender();
				sent++;
			end
			// Hold off once until the display side has drained
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				idle_sender(1);
				while (board.pending() != 0) @(posedge clk);
			end
		end

		idle_sender(1);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report_mismatch($sformatf("%0d digits never arrived", board.pending()));

		if (board.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
